// ===== hw/rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps

package bsc_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_LOAD_AVAIL = 2'd0;
  localparam logic [1:0] OP_LOAD_ENTRY = 2'd1;
  localparam logic [1:0] OP_CHECK      = 2'd2;

  // configuration register indexes
  localparam logic REG_PROCS = 1'b0;
  localparam logic REG_RES   = 1'b1;

  // configuration reset values
  localparam logic [3:0] PROCS_RESET = 4'd8;
  localparam logic [2:0] RES_RESET   = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_avail;  // write the free-unit table
    logic load_entry;  // write allocation and need of one process/resource
    logic start;       // copy free units into the working store, clear finish marks
    logic fit_init;    // begin the test of one process
    logic rd_en;       // read one table entry of the process under test
    logic decide;      // finish the process if it fit
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cur_finished;  // process under test is already finished
    logic fit;           // every resource read so far fits
  } status_t;

endpackage

// ===== hw/rtl/bsc_dpath.sv =====
`timescale 1ns / 1ps

module bsc_dpath
  import bsc_pkg::*;
#(
  parameter int MAX_PROCS   = 8,
  parameter int MAX_RES     = 4,
  parameter int AMOUNT_BITS = 8,
  parameter int PROC_IW     = 3,
  parameter int RES_IW      = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic [PROC_IW-1:0] proc_idx,
  input  logic [RES_IW-1:0]  res_idx,
  input  logic [PROC_IW-1:0] seq_idx,
  input  logic [PROC_IW-1:0] emit_idx,
  input  logic [2:0]         in_proc,
  input  logic [1:0]         in_res,
  input  logic [7:0]         in_alloc,
  input  logic [7:0]         in_max,
  input  logic [7:0]         in_avail,
  output logic [2:0]         seq_rd
);

  localparam int ADDR_W = PROC_IW + RES_IW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int WORK_W = AMOUNT_BITS + 4;

  // input fields widened, then cut to the amount width
  logic [31:0]            p_ext, r_ext, a_ext, m_ext, v_ext;
  logic [AMOUNT_BITS-1:0] amt_a, amt_m, amt_v, need_val;
  logic                   p_ok, r_ok;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;

  assign p_ext    = 32'(in_proc);
  assign r_ext    = 32'(in_res);
  assign a_ext    = 32'(in_alloc);
  assign m_ext    = 32'(in_max);
  assign v_ext    = 32'(in_avail);
  assign amt_a    = a_ext[AMOUNT_BITS-1:0];
  assign amt_m    = m_ext[AMOUNT_BITS-1:0];
  assign amt_v    = v_ext[AMOUNT_BITS-1:0];
  assign need_val = (amt_m > amt_a) ? (amt_m - amt_a) : '0;
  assign p_ok     = (p_ext < MAX_PROCS);
  assign r_ok     = (r_ext < MAX_RES);
  assign wr_addr  = {p_ext[PROC_IW-1:0], r_ext[RES_IW-1:0]};
  assign rd_addr  = {proc_idx, res_idx};

  // allocation and need tables
  logic [AMOUNT_BITS-1:0] alloc_mem [DEPTH];
  logic [AMOUNT_BITS-1:0] need_mem  [DEPTH];
  logic [AMOUNT_BITS-1:0] rd_alloc_r, rd_need_r;
  logic [RES_IW-1:0]      rd_j_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.load_entry && p_ok && r_ok) begin
      alloc_mem[wr_addr] <= amt_a;
      need_mem[wr_addr]  <= need_val;
    end
    if (cmd.rd_en) begin
      rd_alloc_r <= alloc_mem[rd_addr];
      rd_need_r  <= need_mem[rd_addr];
      rd_j_r     <= res_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  // loaded free units
  logic [AMOUNT_BITS-1:0] avail_r [MAX_RES];

  always_ff @(posedge clk) begin
    if (cmd.load_avail && r_ok) begin
      avail_r[r_ext[RES_IW-1:0]] <= amt_v;
    end
  end

  // fit test and saturating sum for the entry just read
  logic [WORK_W-1:0] work_r [MAX_RES];
  logic [WORK_W-1:0] tmp_r  [MAX_RES];
  logic [WORK_W-1:0] work_sel, need_ext, sum_sat;
  logic [WORK_W:0]   sum;
  logic              fit_r;

  assign work_sel = work_r[rd_j_r];
  assign need_ext = WORK_W'(rd_need_r);
  assign sum      = {1'b0, work_sel} + (WORK_W + 1)'(rd_alloc_r);
  assign sum_sat  = sum[WORK_W] ? '1 : sum[WORK_W-1:0];

  // working store commits the staged sums only when the whole process fits
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (cmd.start) begin
        work_r[j] <= WORK_W'(avail_r[j]);
      end else if (cmd.decide && fit_r) begin
        work_r[j] <= tmp_r[j];
      end
    end
    if (cmd.fit_init) begin
      for (int j = 0; j < MAX_RES; j++) begin
        tmp_r[j] <= work_r[j];
      end
    end else if (rd_vld_r) begin
      tmp_r[rd_j_r] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= 1'b0;
    end else if (cmd.fit_init) begin
      fit_r <= 1'b1;
    end else if (rd_vld_r && (need_ext > work_sel)) begin
      fit_r <= 1'b0;
    end
  end

  // finish marks and safe sequence
  logic [MAX_PROCS-1:0] marks_r;
  logic [PROC_IW-1:0]   seq_r [MAX_PROCS];
  logic [31:0]          seq_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else if (cmd.start) begin
      marks_r <= '0;
    end else if (cmd.decide && fit_r) begin
      marks_r[proc_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && fit_r) begin
      seq_r[seq_idx] <= proc_idx;
    end
  end

  assign seq_ext          = 32'(seq_r[emit_idx]);
  assign seq_rd           = seq_ext[2:0];
  assign sts.cur_finished = marks_r[proc_idx];
  assign sts.fit          = fit_r;

endmodule

// ===== hw/rtl/bsc_ctrl.sv =====
`timescale 1ns / 1ps

module bsc_ctrl
  import bsc_pkg::*;
#(
  parameter int MAX_PROCS = 8,
  parameter int MAX_RES   = 4,
  parameter int PROC_IW   = 3,
  parameter int RES_IW    = 2,
  parameter int CNT_W     = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata,
  input  logic               in_tvalid,
  input  logic [1:0]         in_op,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               out_safe,
  output logic [2:0]         out_pos,
  output logic               out_last,
  output cmd_t               cmd,
  input  status_t            sts,
  output logic [PROC_IW-1:0] proc_idx,
  output logic [RES_IW-1:0]  res_idx,
  output logic [PROC_IW-1:0] seq_idx,
  output logic [PROC_IW-1:0] emit_idx
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_START    = 8'b0000_0010,
    ST_SELECT   = 8'b0000_0100,
    ST_ISSUE    = 8'b0000_1000,
    ST_DRAIN    = 8'b0001_0000,
    ST_DECIDE   = 8'b0010_0000,
    ST_PASS_END = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  // configuration registers
  logic [3:0] procs_r;
  logic [2:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      procs_r <= PROCS_RESET;
      res_r   <= RES_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROCS: procs_r <= cfg_wdata;
        REG_RES:   res_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // last process and resource in use, saturated to the table size
  logic [PROC_IW-1:0] np_m1;
  logic [RES_IW-1:0]  nr_m1;
  logic [CNT_W-1:0]   np_cnt;

  always_comb begin
    if (procs_r == '0) begin
      np_m1 = '0;
    end else if (32'(procs_r) > MAX_PROCS) begin
      np_m1 = PROC_IW'(MAX_PROCS - 1);
    end else begin
      np_m1 = PROC_IW'(procs_r - 4'd1);
    end
    if (res_r == '0) begin
      nr_m1 = '0;
    end else if (32'(res_r) > MAX_RES) begin
      nr_m1 = RES_IW'(MAX_RES - 1);
    end else begin
      nr_m1 = RES_IW'(res_r - 3'd1);
    end
  end

  assign np_cnt = CNT_W'(np_m1) + CNT_W'(1);

  state_t             state_r, state_nxt;
  logic [PROC_IW-1:0] i_r, i_nxt;
  logic [RES_IW-1:0]  j_r, j_nxt;
  logic [PROC_IW-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               progress_r, progress_nxt;
  logic               unsafe_r, unsafe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      count_r    <= '0;
      progress_r <= 1'b0;
      unsafe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      count_r    <= count_nxt;
      progress_r <= progress_nxt;
      unsafe_r   <= unsafe_nxt;
    end
  end

  // sequencer over passes, processes and resources
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    count_nxt    = count_r;
    progress_nxt = progress_r;
    unsafe_nxt   = unsafe_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_LOAD_AVAIL: cmd.load_avail = 1'b1;
            OP_LOAD_ENTRY: cmd.load_entry = 1'b1;
            OP_CHECK:      state_nxt = ST_START;
            default: ;
          endcase
        end
      end
      ST_START: begin
        cmd.start    = 1'b1;
        count_nxt    = '0;
        progress_nxt = 1'b0;
        i_nxt        = '0;
        state_nxt    = ST_SELECT;
      end
      ST_SELECT: begin
        if (sts.cur_finished) begin
          if (i_r == np_m1) begin
            state_nxt = ST_PASS_END;
          end else begin
            i_nxt = i_r + PROC_IW'(1);
          end
        end else begin
          cmd.fit_init = 1'b1;
          j_nxt        = '0;
          state_nxt    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (j_r == nr_m1) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + RES_IW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.fit) begin
          count_nxt    = count_r + CNT_W'(1);
          progress_nxt = 1'b1;
        end
        if (i_r == np_m1) begin
          state_nxt = ST_PASS_END;
        end else begin
          i_nxt     = i_r + PROC_IW'(1);
          state_nxt = ST_SELECT;
        end
      end
      ST_PASS_END: begin
        if (!progress_r) begin
          unsafe_nxt = 1'b1;
          k_nxt      = '0;
          state_nxt  = ST_EMIT;
        end else if (count_r == np_cnt) begin
          unsafe_nxt = 1'b0;
          k_nxt      = '0;
          state_nxt  = ST_EMIT;
        end else begin
          progress_nxt = 1'b0;
          i_nxt        = '0;
          state_nxt    = ST_SELECT;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          if (unsafe_r || (k_r == np_m1)) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + PROC_IW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields
  logic [31:0] k_ext;

  assign k_ext      = 32'(k_r);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_safe   = !unsafe_r;
  assign out_pos    = unsafe_r ? 3'd0 : k_ext[2:0];
  assign out_last   = unsafe_r || (k_r == np_m1);
  assign proc_idx   = i_r;
  assign res_idx    = j_r;
  assign seq_idx    = count_r[PROC_IW-1:0];
  assign emit_idx   = k_r;

endmodule

// ===== hw/rtl/bankers_safety_check_unit.sv =====
`timescale 1ns / 1ps

// Banker's algorithm safety check. Load transfers (one per cycle while no check is in
// progress) fill the free-unit table and the per-process allocation/need tables; a check
// transfer runs the safety test and then returns either the safe sequence (one transfer
// per process in use, tlast on the final one) or a single unsafe transfer. A check passes
// a start state, then in each pass skips every already-finished process in the select
// state, and for each open process selects it, reads its resources in use, drains and
// decides; each pass closes in a pass-end state, and then the results are emitted.
// The single read port of the allocation/need tables is walked by the sequencer one
// resource per cycle, and a check runs up to procs_in_use passes.
// No new item is taken while a check is in progress.

module bankers_safety_check_unit
  import bsc_pkg::*;
#(
  parameter int MAX_PROCS   = 8,
  parameter int MAX_RES     = 4,
  parameter int AMOUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // process_index[2:0], resource_index[4:3], alloc_amount[12:5],
  // max_amount[20:13], avail_amount[28:21], zero fill above
  input  logic [31:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // safe[0], served_process[3:1], position[6:4], zero fill above
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  localparam int PROC_IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RES_IW  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);

  cmd_t               cmd;
  status_t            sts;
  logic [PROC_IW-1:0] proc_idx, seq_idx, emit_idx;
  logic [RES_IW-1:0]  res_idx;
  logic               out_safe;
  logic [2:0]         out_pos, seq_rd, served;

  bsc_ctrl #(
    .MAX_PROCS (MAX_PROCS),
    .MAX_RES   (MAX_RES),
    .PROC_IW   (PROC_IW),
    .RES_IW    (RES_IW),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_safe   (out_safe),
    .out_pos    (out_pos),
    .out_last   (out_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .proc_idx   (proc_idx),
    .res_idx    (res_idx),
    .seq_idx    (seq_idx),
    .emit_idx   (emit_idx)
  );

  bsc_dpath #(
    .MAX_PROCS   (MAX_PROCS),
    .MAX_RES     (MAX_RES),
    .AMOUNT_BITS (AMOUNT_BITS),
    .PROC_IW     (PROC_IW),
    .RES_IW      (RES_IW)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .proc_idx (proc_idx),
    .res_idx  (res_idx),
    .seq_idx  (seq_idx),
    .emit_idx (emit_idx),
    .in_proc  (in_tdata[2:0]),
    .in_res   (in_tdata[4:3]),
    .in_alloc (in_tdata[12:5]),
    .in_max   (in_tdata[20:13]),
    .in_avail (in_tdata[28:21]),
    .seq_rd   (seq_rd)
  );

  // unsafe result carries zero process
  assign served    = out_safe ? seq_rd : 3'd0;
  assign out_tdata = {1'b0, out_pos, served, out_safe};

  // an unsafe result is always the only and last one
  a_unsafe_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> out_tlast)
    else $error("unsafe result without tlast");

  // input side is closed while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a check closes the input side on the following cycle
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_CHECK)) |=> !in_tready)
    else $error("input ready right after a check transfer");

  // an unsafe result reports position zero
  a_unsafe_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[6:1] == 6'd0))
    else $error("unsafe result with nonzero fields");

endmodule
